/* hdl/gbfp_pkg.sv */
// Shared constants of the GPS binary frame parser.
// Used by the top level.
package gbfp_pkg;

   localparam logic [7:0] SYNC_FIRST     = 8'hD0;
   localparam logic [7:0] SYNC_SECOND    = 8'hDD;
   localparam logic [7:0] FIX_CODE_RESET = 8'd3;

   // Frame position codes
   localparam logic [5:0] POS_IDLE        = 6'd0;
   localparam logic [5:0] POS_SYNC2       = 6'd1;
   localparam logic [5:0] POS_TIME_DONE   = 6'd33;
   localparam logic [5:0] POS_PAYLOAD_END = 6'd34;
   localparam logic [5:0] POS_CKA         = 6'd35;
   localparam logic [5:0] POS_LAST        = 6'd36;

   // Payload bytes held in the shift line (frame positions 2..34)
   localparam int SHIFT_DEPTH = 33;

endpackage

/* hdl/gbfp_day_ms.sv */
// Staged converter from an hhmmssmmm time word to milliseconds of day.
// Stands alone; the top level advances it on the frame's trailing bytes.
module gbfp_day_ms (
   input  logic        clock,
   input  logic        load,
   input  logic        step_hour,
   input  logic        step_min,
   input  logic [31:0] time_word,
   output logic [31:0] value
);

   localparam logic [31:0] HOUR_DIV   = 32'd10000000;
   localparam logic [31:0] HOUR_MS    = 32'd3600000;
   localparam logic [31:0] MIN_NET_MS = 32'd40000;     // 100000 out, 60000 back in
   localparam logic [25:0] HOUR_RECIP = 26'd56294996;  // ceil(2^42 / 78125)
   localparam logic [19:0] MIN_RECIP  = 20'd687195;    // ceil(2^31 / 3125)

   logic [8:0]  hours_ff, hours_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] hour_ms_ff, hour_ms_in;
   logic [6:0]  mins_ff, mins_in;
   logic [50:0] hour_prod;
   logic [38:0] min_prod;

   // hours = floor(t / 10^7) = floor((t >> 7) / 78125), exact for any 25-bit input
   assign hour_prod = time_word[31:7] * HOUR_RECIP;
   assign hours_in  = hour_prod[50:42];

   // Drop the hours; the remainder stays below 10^7
   assign rem_in     = rem_ff - {23'd0, hours_ff} * HOUR_DIV;
   assign hour_ms_in = {23'd0, hours_ff} * HOUR_MS;

   // minutes = floor(r / 10^5) = floor((r >> 5) / 3125), exact for any remainder below 10^7
   assign min_prod = rem_ff[23:5] * MIN_RECIP;
   assign mins_in  = min_prod[37:31];

   // hours*3600000 + mins*60000 + (r - mins*100000)
   assign value = hour_ms_ff + rem_ff - {25'd0, mins_ff} * MIN_NET_MS;

   always_ff @(posedge clock) begin
      if (load) begin
         hours_ff <= hours_in;
         rem_ff   <= time_word;
      end else if (step_hour) begin
         rem_ff     <= rem_in;
         hour_ms_ff <= hour_ms_in;
      end
      if (step_min) mins_ff <= mins_in;
   end

endmodule

/* hdl/gps_binary_frame_parser_top.sv */
// Top level of the GPS binary frame parser with Fletcher-8 check.
// Depends on gbfp_pkg and gbfp_day_ms.
//
// Usage:
//   req_ channel: one received serial byte per transfer (req_valid high,
//   req_stall low). Bytes are framed: 0xD0 opens a frame, other bytes are
//   dropped until 0xDD, then 35 more bytes follow; the last of them yields
//   one result on the rsp_ channel.
//   rsp_ channel: one record per completed frame. checksum_ok and
//   position_valid flag a good frame; a failed frame repeats the last good
//   record with both flags low.
//   Output: the result is on rsp_ in the cycle after a frame's last byte is
//   taken, good or failed. The time-of-day conversion advances in stages on
//   the transfers of bytes 33..35, so the last byte only adds the final sum.
//   Throughput: one byte per cycle unless stalled; at most one result per 37 bytes.
//   Stall: a held result stays on rsp_ until transferred. Only the last byte
//   of a frame is stalled, and only while the previous result still waits;
//   every other byte is taken at once.
//   Reset: clears framing, sums and the held record, and loads fix code 3.
//   csr_: write csr_wr_data into the full-fix code when csr_wr_en is high.
module gps_binary_frame_parser_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [7:0]         csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_checksum_ok,
   output logic               rsp_position_valid,
   output logic signed [31:0] rsp_latitude,
   output logic signed [31:0] rsp_longitude,
   output logic [31:0]        rsp_altitude_cm,
   output logic [31:0]        rsp_speed_raw,
   output logic [31:0]        rsp_heading_raw,
   output logic [7:0]         rsp_satellite_count,
   output logic [7:0]         rsp_fix_type,
   output logic [31:0]        rsp_fix_date,
   output logic [31:0]        rsp_day_milliseconds,
   output logic [15:0]        rsp_hdop
);
   import gbfp_pkg::*;

   logic [7:0]  fix_code_ff;
   logic [5:0]  pos_ff, pos_in;
   logic [7:0]  sum1_ff, sum1_in;
   logic [7:0]  sum2_ff, sum2_in;
   logic [7:0]  cka_ff;
   logic [7:0]  shift_ff [SHIFT_DEPTH];

   // Held record, shown on the rsp_ ports
   logic [31:0] lat_ff, lon_ff, alt_ff, spd_ff, hdg_ff, date_ff, dms_ff;
   logic [7:0]  sat_ff, fix_ff;
   logic [15:0] hdop_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        ok_ff, pv_ff;

   logic        req_xfer, rsp_xfer;
   logic        last_xfer, frame_ok, good_xfer;
   logic        shift_en;
   logic        dms_load, dms_step_hour, dms_step_min;
   logic [31:0] time_word;
   logic [31:0] dms_value;

   assign req_stall = (pos_ff == POS_LAST) && rsp_valid_ff;
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;

   assign last_xfer = req_xfer && (pos_ff == POS_LAST);
   assign frame_ok  = (sum1_ff == cka_ff) && (sum2_ff == req_rx_byte);
   assign good_xfer = last_xfer && frame_ok;
   assign shift_en  = req_xfer && (pos_ff > POS_SYNC2) && (pos_ff <= POS_PAYLOAD_END);

   // Advance the time conversion on the transfers of bytes 33, 34 and 35
   assign dms_load      = req_xfer && (pos_ff == POS_TIME_DONE);
   assign dms_step_hour = req_xfer && (pos_ff == POS_PAYLOAD_END);
   assign dms_step_min  = req_xfer && (pos_ff == POS_CKA);

   // While byte 33 is offered, frame positions 29..32 sit at entries 29..32
   assign time_word = {shift_ff[32], shift_ff[31], shift_ff[30], shift_ff[29]};

   // Framing and Fletcher-8 sums
   always_comb begin
      pos_in  = pos_ff;
      sum1_in = sum1_ff;
      sum2_in = sum2_ff;
      if (req_xfer) begin
         if (pos_ff == POS_IDLE) begin
            if (req_rx_byte == SYNC_FIRST) pos_in = POS_SYNC2;
         end else if (pos_ff == POS_SYNC2) begin
            // Drop anything but the second sync byte and keep waiting
            if (req_rx_byte == SYNC_SECOND) begin
               pos_in  = pos_ff + 6'd1;
               sum1_in = 8'd0;
               sum2_in = 8'd0;
            end
         end else if (pos_ff == POS_LAST) begin
            pos_in  = POS_IDLE;
            sum1_in = 8'd0;
            sum2_in = 8'd0;
         end else begin
            pos_in = pos_ff + 6'd1;
            if (pos_ff <= POS_PAYLOAD_END) begin
               sum1_in = sum1_ff + req_rx_byte;
               sum2_in = sum2_ff + sum1_ff + req_rx_byte;
            end
         end
      end
   end

   // Result flag: set by the last byte of any frame; drop it on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_xfer) rsp_valid_in = 1'b0;
      if (last_xfer) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fix_code_ff  <= FIX_CODE_RESET;
         pos_ff       <= POS_IDLE;
         sum1_ff      <= 8'd0;
         sum2_ff      <= 8'd0;
         rsp_valid_ff <= 1'b0;
         ok_ff        <= 1'b0;
         pv_ff        <= 1'b0;
         lat_ff       <= 32'd0;
         lon_ff       <= 32'd0;
         alt_ff       <= 32'd0;
         spd_ff       <= 32'd0;
         hdg_ff       <= 32'd0;
         sat_ff       <= 8'd0;
         fix_ff       <= 8'd0;
         date_ff      <= 32'd0;
         dms_ff       <= 32'd0;
         hdop_ff      <= 16'd0;
      end else begin
         if (csr_wr_en) fix_code_ff <= csr_wr_data;
         pos_ff       <= pos_in;
         sum1_ff      <= sum1_in;
         sum2_ff      <= sum2_in;
         rsp_valid_ff <= rsp_valid_in;
         if (last_xfer) begin
            ok_ff <= frame_ok;
            pv_ff <= frame_ok && (shift_ff[22] == fix_code_ff);
         end
         // Decode the little-endian fields of a good frame
         if (good_xfer) begin
            lat_ff  <= {shift_ff[4],  shift_ff[3],  shift_ff[2],  shift_ff[1]};
            lon_ff  <= {shift_ff[8],  shift_ff[7],  shift_ff[6],  shift_ff[5]};
            alt_ff  <= {shift_ff[12], shift_ff[11], shift_ff[10], shift_ff[9]};
            spd_ff  <= {shift_ff[16], shift_ff[15], shift_ff[14], shift_ff[13]};
            hdg_ff  <= {shift_ff[20], shift_ff[19], shift_ff[18], shift_ff[17]};
            sat_ff  <= shift_ff[21];
            fix_ff  <= shift_ff[22];
            date_ff <= {shift_ff[26], shift_ff[25], shift_ff[24], shift_ff[23]};
            dms_ff  <= dms_value;
            hdop_ff <= {shift_ff[32], shift_ff[31]};
         end
      end
   end

   // Payload shift line: after position 34, entry k holds frame byte k+2
   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int k = 0; k < SHIFT_DEPTH - 1; k++) shift_ff[k] <= shift_ff[k+1];
         shift_ff[SHIFT_DEPTH-1] <= req_rx_byte;
      end
      if (req_xfer && (pos_ff == POS_CKA)) cka_ff <= req_rx_byte;
   end

   gbfp_day_ms u_day_ms (
      .clock     (clock),
      .load      (dms_load),
      .step_hour (dms_step_hour),
      .step_min  (dms_step_min),
      .time_word (time_word),
      .value     (dms_value)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_checksum_ok      = ok_ff;
   assign rsp_position_valid   = pv_ff;
   assign rsp_latitude         = signed'(lat_ff);
   assign rsp_longitude        = signed'(lon_ff);
   assign rsp_altitude_cm      = alt_ff;
   assign rsp_speed_raw        = spd_ff;
   assign rsp_heading_raw      = hdg_ff;
   assign rsp_satellite_count  = sat_ff;
   assign rsp_fix_type         = fix_ff;
   assign rsp_fix_date         = date_ff;
   assign rsp_day_milliseconds = dms_ff;
   assign rsp_hdop             = hdop_ff;

endmodule

/* hdl/gbfp_checker.sv */
// Port-level checker for the GPS binary frame parser, bound to the top.
// Depends only on the top level's ports.
module gbfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_checksum_ok,
   input logic        rsp_position_valid,
   input logic [31:0] rsp_day_milliseconds
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_day_milliseconds))
      else $error("stalled result changed");

   // A good fix implies a good checksum
   a_pv_needs_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_position_valid |-> rsp_checksum_ok)
      else $error("position valid without checksum");

   a_bad_no_pv: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_checksum_ok |-> !rsp_position_valid)
      else $error("failed frame flagged position valid");

   // Results are a full frame apart: never two transfers in a row
   a_no_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid)
      else $error("result right after a transfer");

endmodule

bind gps_binary_frame_parser_top gbfp_checker u_gbfp_checker (.*);
